/* sv/brf_pkg.sv */
// Shared constants, codes and types for the byte ring FIFO.
`default_nettype none

package brf_pkg;

	// ring geometry
	localparam int RING_DEPTH = 256;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int CAP_W      = PTR_W + 1;
	localparam int BYTE_W     = 8;

	localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(2);
	localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(RING_DEPTH);
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

	// request codes
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_PEEK  = 2'd2;
	localparam logic [1:0] REQ_CLEAR = 2'd3;

	// status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	// byte returned by a read of an empty ring
	localparam logic [BYTE_W-1:0] EMPTY_READ_BYTE = BYTE_W'(128);

	// controller -> datapath commands
	typedef struct packed {
		logic exec;   // request accepted this cycle
		logic load;   // move result into output register
	} brf_cmd_t;

endpackage

`default_nettype wire

/* sv/brf_ctrl.sv */
// Controller: request sequencing and output valid for the byte ring FIFO.
`default_nettype none

module brf_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output brf_pkg::brf_cmd_t    cmd
);

	localparam logic ST_IDLE = 1'b0;   // waiting for a request
	localparam logic ST_LOAD = 1'b1;   // memory read done, result waits for output slot

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign cmd.exec  = in_valid && in_ready;
	assign cmd.load  = (state_q == ST_LOAD) && slot_free;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.exec) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/brf_datapath.sv */
// Datapath: ring memory, pointers, counters and output register.
`default_nettype none

module brf_datapath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire brf_pkg::brf_cmd_t            cmd,
	input  wire logic [1:0]                   req_type,
	input  wire logic [brf_pkg::BYTE_W-1:0]   write_data,
	input  wire logic                         cfg_we,
	input  wire logic [brf_pkg::CAP_W-1:0]    cfg_wdata,
	output logic [brf_pkg::BYTE_W-1:0]        read_data,
	output logic [1:0]                        status,
	output logic [brf_pkg::PTR_W-1:0]         fill_length,
	output logic [brf_pkg::PTR_W-1:0]         head_index,
	output logic [brf_pkg::PTR_W-1:0]         tail_index,
	output logic [brf_pkg::BYTE_W-1:0]        overflow_total
);

	// read data source for the pending result
	localparam logic [1:0] RDSEL_ZERO  = 2'd0;
	localparam logic [1:0] RDSEL_EMPTY = 2'd1;
	localparam logic [1:0] RDSEL_MEM   = 2'd2;

	function automatic logic [brf_pkg::PTR_W-1:0] advance(
		input logic [brf_pkg::PTR_W-1:0] p,
		input logic [brf_pkg::CAP_W-1:0] cap
	);
		logic [brf_pkg::CAP_W-1:0] last;
		last = cap - brf_pkg::CAP_W'(1);
		if ({1'b0, p} < last) begin
			return p + brf_pkg::PTR_W'(1);
		end
		return '0;
	endfunction

	logic [brf_pkg::BYTE_W-1:0] ring_mem [brf_pkg::RING_DEPTH];
	logic [brf_pkg::BYTE_W-1:0] mem_rd_q;

	logic [brf_pkg::CAP_W-1:0]  cap_q;
	logic [brf_pkg::PTR_W-1:0]  rp_q;
	logic [brf_pkg::PTR_W-1:0]  wp_q;
	logic [brf_pkg::PTR_W-1:0]  fill_q;
	logic [brf_pkg::BYTE_W-1:0] drop_q;
	logic [1:0]                 res_status_q;
	logic [1:0]                 res_rdsel_q;

	logic [brf_pkg::BYTE_W-1:0] read_data_q;
	logic [1:0]                 status_q;
	logic [brf_pkg::PTR_W-1:0]  fill_out_q;
	logic [brf_pkg::PTR_W-1:0]  head_out_q;
	logic [brf_pkg::PTR_W-1:0]  tail_out_q;
	logic [brf_pkg::BYTE_W-1:0] drop_out_q;

	logic [brf_pkg::CAP_W-1:0]  cap_clamped;
	logic                       is_full;
	logic                       is_empty;
	logic                       do_mem_wr;
	logic                       do_mem_rd;
	logic [brf_pkg::BYTE_W-1:0] rd_value;

	assign is_full  = ({1'b0, fill_q} == (cap_q - brf_pkg::CAP_W'(1)));
	assign is_empty = (fill_q == '0);

	assign do_mem_wr = cmd.exec && (req_type == brf_pkg::REQ_WRITE) && !is_full;
	assign do_mem_rd = cmd.exec && !is_empty
		&& ((req_type == brf_pkg::REQ_READ) || (req_type == brf_pkg::REQ_PEEK));

	always_comb begin
		if (cfg_wdata < brf_pkg::CAP_MIN) begin
			cap_clamped = brf_pkg::CAP_MIN;
		end else if (cfg_wdata > brf_pkg::CAP_MAX) begin
			cap_clamped = brf_pkg::CAP_MAX;
		end else begin
			cap_clamped = cfg_wdata;
		end
	end

	// ring memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (do_mem_wr) begin
			ring_mem[wp_q] <= write_data;
		end
		if (do_mem_rd) begin
			mem_rd_q <= ring_mem[rp_q];
		end
	end

	// pointers, counters, pending result code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q        <= brf_pkg::CAP_RESET;
			rp_q         <= '0;
			wp_q         <= '0;
			fill_q       <= '0;
			drop_q       <= '0;
			res_status_q <= brf_pkg::STAT_OK;
			res_rdsel_q  <= RDSEL_ZERO;
		end else if (cfg_we) begin
			// capacity write also empties the ring
			cap_q  <= cap_clamped;
			rp_q   <= '0;
			wp_q   <= '0;
			fill_q <= '0;
			drop_q <= '0;
		end else if (cmd.exec) begin
			res_status_q <= brf_pkg::STAT_OK;
			res_rdsel_q  <= RDSEL_ZERO;
			unique case (req_type)
				brf_pkg::REQ_WRITE: begin
					if (is_full) begin
						drop_q       <= drop_q + brf_pkg::BYTE_W'(1);
						res_status_q <= brf_pkg::STAT_FULL;
					end else begin
						wp_q   <= advance(wp_q, cap_q);
						fill_q <= fill_q + brf_pkg::PTR_W'(1);
					end
				end
				brf_pkg::REQ_READ: begin
					if (is_empty) begin
						res_status_q <= brf_pkg::STAT_EMPTY;
						res_rdsel_q  <= RDSEL_EMPTY;
					end else begin
						rp_q        <= advance(rp_q, cap_q);
						fill_q      <= fill_q - brf_pkg::PTR_W'(1);
						res_rdsel_q <= RDSEL_MEM;
					end
				end
				brf_pkg::REQ_PEEK: begin
					if (is_empty) begin
						res_status_q <= brf_pkg::STAT_EMPTY;
					end else begin
						res_rdsel_q <= RDSEL_MEM;
					end
				end
				brf_pkg::REQ_CLEAR: begin
					rp_q   <= '0;
					wp_q   <= '0;
					fill_q <= '0;
					drop_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (res_rdsel_q)
			RDSEL_MEM:   rd_value = mem_rd_q;
			RDSEL_EMPTY: rd_value = brf_pkg::EMPTY_READ_BYTE;
			default:     rd_value = '0;
		endcase
	end

	// output register; pointer state is frozen between exec and load, unless a capacity write comes in between
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			read_data_q <= rd_value;
			status_q    <= res_status_q;
			fill_out_q  <= fill_q;
			head_out_q  <= rp_q;
			tail_out_q  <= wp_q;
			drop_out_q  <= drop_q;
		end
	end

	assign read_data      = read_data_q;
	assign status         = status_q;
	assign fill_length    = fill_out_q;
	assign head_index     = head_out_q;
	assign tail_index     = tail_out_q;
	assign overflow_total = drop_out_q;

	a_fill_below_cap: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, fill_q} < cap_q)
		else $error("fill count reached capacity");

	a_ptrs_below_cap: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, rp_q} < cap_q) && ({1'b0, wp_q} < cap_q))
		else $error("ring pointer beyond capacity");

	a_fill_matches_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(rp_q <= wp_q) ? (fill_q == (wp_q - rp_q))
			: ({1'b0, fill_q} == (cap_q + {1'b0, wp_q} - {1'b0, rp_q})))
		else $error("fill count out of step with pointers");

	a_no_wr_and_rd: assert property (@(posedge clk) disable iff (!arst_n)
		!(do_mem_wr && do_mem_rd))
		else $error("ring memory read and write in one request");

endmodule

`default_nettype wire

/* sv/byte_ring_fifo_overflow_count.sv */
// Top level of the byte ring FIFO with overflow counter.
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  request | in_valid / in_ready   | req_type, write_data
//  result  | out_valid / out_ready | read_data, status, fill_length, head_index,
//          |                       | tail_index, overflow_total
//  config  | cfg_we                | cfg_wdata (ring capacity, clamped to 2..256)
//
// A request is accepted first: the accept cycle updates pointers and issues the
// ring memory access; then the registered memory read is loaded into the output
// register once it is free. The memory's registered read port sets this order.
// Reset (arst_n low) empties the ring and sets capacity to 256; the ring memory
// itself is not cleared and needs no clearing pass.
// A result waiting on out_ready does not block the next request's accept; that
// request's result then holds until the output register frees up.
// A capacity write empties the ring and clears the overflow count.
`default_nettype none

module byte_ring_fifo_overflow_count (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// request channel
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   req_type,
	input  wire logic [brf_pkg::BYTE_W-1:0]   write_data,
	// result channel
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [brf_pkg::BYTE_W-1:0]        read_data,
	output logic [1:0]                        status,
	output logic [brf_pkg::PTR_W-1:0]         fill_length,
	output logic [brf_pkg::PTR_W-1:0]         head_index,
	output logic [brf_pkg::PTR_W-1:0]         tail_index,
	output logic [brf_pkg::BYTE_W-1:0]        overflow_total,
	// capacity register
	input  wire logic                         cfg_we,
	input  wire logic [brf_pkg::CAP_W-1:0]    cfg_wdata
);

	brf_pkg::brf_cmd_t cmd;

	// sequencing: accept, then result load into the output register
	brf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// ring storage, head/tail pointers, fill and overflow counters
	brf_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.req_type       (req_type),
		.write_data     (write_data),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.read_data      (read_data),
		.status         (status),
		.fill_length    (fill_length),
		.head_index     (head_index),
		.tail_index     (tail_index),
		.overflow_total (overflow_total)
	);

endmodule

`default_nettype wire
